@@ design/uit_pkg.sv @@
// Shared widths, command and status codes for the unique integer table.
package uit_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int CMD_W      = 3;
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 6;
  localparam int STAT_W     = 2;
  localparam int POS_W      = 6;
  localparam int CNT_W      = 7;
  localparam int CAP_W      = 7;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_UNIQUE = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISS    = 2'd3
  } status_t;

endpackage

@@ design/uit_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module uit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/unique_integer_table.sv @@
// Top level of the unique integer table: command decode, search sequencer and result register.
//
// Usage: each item on the in_ channel is one command (clear, append, append
// unique, find, read) and gives exactly one item on the out_ channel. The
// entries live in one RAM with a registered read; searches walk the filled
// entries one RAM read per cycle, lowest position first.
// One command is in work at a time; the next is accepted once the result
// has moved into the output register, which holds it until out_tready.
// A stalled receiver therefore lets at most one further command be accepted.
// Reset empties the table (fill count zero) and sets capacity to 64; the
// RAM contents are not cleared since only written entries are ever read.
// The cfg_ channel writes capacity at any time and is always ready; it is
// meant to be written while no command is in work.
module unique_integer_table #(
  parameter int DEPTH = uit_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: value[31:0], index[37:32], zero fill [39:38]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [uit_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: cmd[2:0]
  input  logic [uit_pkg::CMD_W-1:0]      in_tuser,
  // out_tdata: position[5:0], data[37:6], entry_count[44:38], zero fill [47:45]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [uit_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: status[1:0]
  output logic [uit_pkg::STAT_W-1:0]     out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uit_pkg::CAP_W-1:0]      cfg_data
);
  import uit_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RDWAIT, S_DONE} state_t;

  state_t           state_r;
  logic [CW-1:0]    count_r;
  logic [CAP_W-1:0] cap_r;
  cmd_t             cmd_r;
  logic [VAL_W-1:0] val_r;
  logic [CW-1:0]    iss_r;
  logic             cmp_v_r;
  logic [AW-1:0]    cmp_addr_r;
  status_t          res_status_r;
  logic [POS_W-1:0] res_pos_r;
  logic [VAL_W-1:0] res_data_r;
  logic             out_valid_r;
  status_t          out_status_r;
  logic [POS_W-1:0] out_pos_r;
  logic [VAL_W-1:0] out_data_r;
  logic [CNT_W-1:0] out_cnt_r;

  cmd_t             in_cmd;
  logic [VAL_W-1:0] in_value;
  logic [IDX_W-1:0] in_index;
  logic             accept;
  logic [CMPW-1:0]  limit;
  logic             full;
  logic             idx_ok;
  logic             issue;
  logic             hit;
  logic             miss;
  logic             out_load;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  assign in_cmd   = cmd_t'(in_tuser);
  assign in_value = in_tdata[VAL_W-1:0];
  assign in_index = in_tdata[VAL_W+IDX_W-1:VAL_W];
  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    limit    = (CMPW'(cap_r) < DEPTH_C) ? CMPW'(cap_r) : DEPTH_C;
    full     = (CMPW'(count_r) >= limit);
    idx_ok   = (CMPW'(in_index) < CMPW'(count_r));
    issue    = (state_r == S_SCAN) && (iss_r < count_r);
    hit      = (state_r == S_SCAN) && cmp_v_r && (ram_rdata == val_r);
    // Nothing left to issue and the last compare missed: the value is absent.
    miss     = (state_r == S_SCAN) && !hit && !issue;
    out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

    ram_we    = 1'b0;
    ram_wdata = in_value;
    ram_waddr = count_r[AW-1:0];
    if (accept && (in_cmd == CMD_APPEND) && !full) begin
      ram_we = 1'b1;
    end else if (miss && (cmd_r == CMD_UNIQUE) && !full) begin
      ram_we    = 1'b1;
      ram_wdata = val_r;
    end

    ram_re    = 1'b0;
    ram_raddr = iss_r[AW-1:0];
    if (accept && (in_cmd == CMD_READ) && idx_ok) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(in_index);
    end else if (issue) begin
      ram_re = 1'b1;
    end
  end

  uit_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      iss_r       <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r   <= in_cmd;
            val_r   <= in_value;
            iss_r   <= '0;
            cmp_v_r <= 1'b0;
            case (in_cmd)
              CMD_CLEAR: begin
                count_r      <= '0;
                res_status_r <= ST_OK;
                res_pos_r    <= '0;
                res_data_r   <= '0;
                state_r      <= S_DONE;
              end
              CMD_APPEND: begin
                res_data_r <= '0;
                state_r    <= S_DONE;
                if (full) begin
                  res_status_r <= ST_FULL;
                  res_pos_r    <= '0;
                end else begin
                  res_status_r <= ST_OK;
                  res_pos_r    <= POS_W'(count_r);
                  count_r      <= count_r + 1'b1;
                end
              end
              CMD_UNIQUE, CMD_FIND: begin
                res_status_r <= ST_OK;
                res_pos_r    <= '0;
                res_data_r   <= '0;
                state_r      <= S_SCAN;
              end
              CMD_READ: begin
                res_pos_r <= in_index;
                if (idx_ok) begin
                  res_status_r <= ST_OK;
                  res_data_r   <= '0;
                  state_r      <= S_RDWAIT;
                end else begin
                  res_status_r <= ST_MISS;
                  res_data_r   <= '1;
                  state_r      <= S_DONE;
                end
              end
              default: begin
                res_status_r <= ST_OK;
                res_pos_r    <= '0;
                res_data_r   <= '0;
                state_r      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            iss_r <= iss_r + 1'b1;
          end
          cmp_v_r    <= issue;
          cmp_addr_r <= iss_r[AW-1:0];
          if (hit) begin
            res_status_r <= (cmd_r == CMD_UNIQUE) ? ST_PRESENT : ST_OK;
            res_pos_r    <= POS_W'(cmp_addr_r);
            state_r      <= S_DONE;
          end else if (miss) begin
            state_r <= S_DONE;
            if (cmd_r == CMD_FIND) begin
              res_status_r <= ST_MISS;
            end else if (full) begin
              res_status_r <= ST_FULL;
            end else begin
              res_pos_r <= POS_W'(count_r);
              count_r   <= count_r + 1'b1;
            end
          end
        end
        S_RDWAIT: begin
          res_data_r <= ram_rdata;
          state_r    <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_pos_r    <= res_pos_r;
            out_data_r   <= res_data_r;
            out_cnt_r    <= CNT_W'(count_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_data_r, out_pos_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(count_r) <= DEPTH_C)
    else $error("fill count exceeds table depth");

  a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !full)
    else $error("entry written while table is at its limit");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iss_r <= count_r)
    else $error("search issued past the filled entries");

  a_count_on_append: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (count_r == $past(count_r) + 1'b1))
    else $error("fill count did not advance after a store");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the unique integer table: directed and random command streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uit_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 10;
  localparam int MAX_GAP = 15;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 80;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 125;
  localparam int POOL_SIZE = 8;
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(CMD_READ + 1);
  localparam logic [CMD_W-1:0] CMD_LAST_CODE = '1;
  localparam logic [IDX_W-1:0] IDX_LAST = '1;

  // Mirrors the table contents, the fill count and the capacity, and keeps
  // the results that accepted commands still owe.
  class table_scoreboard;
    typedef struct {
      status_t          status;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] data;
      logic [CNT_W-1:0] count;
    } result_t;

    logic [VAL_W-1:0] entries [DEPTH_DEF];
    int unsigned      fill;
    int unsigned      capacity;
    result_t          owed_q[$];
    int unsigned      fails;
    int unsigned      checked;
    int unsigned      print_cap;

    function new();
      fill = 0;
      capacity = CAP_RESET;
      fails = 0;
      checked = 0;
      print_cap = 30;
    endfunction

    function void set_capacity(input logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void note_cmd(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] value,
                           input logic [IDX_W-1:0] idx);
      result_t     r;
      int unsigned limit;
      int unsigned i;
      bit          hit;
      r.status = ST_OK;
      r.position = '0;
      r.data = '0;
      limit = (capacity < DEPTH_DEF) ? capacity : DEPTH_DEF;
      hit = 1'b0;
      // The search covers every filled entry, even when capacity was lowered below the count.
      if (cmd == CMD_UNIQUE || cmd == CMD_FIND) begin
        for (i = 0; i < fill && !hit; i++) begin
          if (entries[i] == value) begin
            hit = 1'b1;
            r.position = i[POS_W-1:0];
          end
        end
      end
      case (cmd)
        CMD_CLEAR: fill = 0;
        CMD_APPEND, CMD_UNIQUE: begin
          if (cmd == CMD_UNIQUE && hit) begin
            r.status = ST_PRESENT;
          end else if (fill >= limit) begin
            r.status = ST_FULL;
          end else begin
            entries[fill] = value;
            r.position = fill[POS_W-1:0];
            fill++;
          end
        end
        CMD_FIND: begin
          if (!hit) r.status = ST_MISS;
        end
        CMD_READ: begin
          r.position = idx;
          if (idx < fill) begin
            r.data = entries[idx];
          end else begin
            r.status = ST_MISS;
            r.data = '1;
          end
        end
        default: ;
      endcase
      r.count = fill[CNT_W-1:0];
      owed_q.push_back(r);
    endfunction

    task report(input string msg);
      if (fails < print_cap) $display("MISMATCH: %s", msg);
      fails++;
    endtask

    task check_result(input logic [OUT_DATA_W-1:0] tdata, input logic [STAT_W-1:0] tuser);
      result_t          want;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] data;
      logic [CNT_W-1:0] cnt;
      pos = tdata[POS_W-1:0];
      data = tdata[POS_W +: VAL_W];
      cnt = tdata[POS_W+VAL_W +: CNT_W];
      checked++;
      if (owed_q.size() == 0) begin
        report($sformatf("result %0d arrived with none outstanding", checked));
        return;
      end
      want = owed_q.pop_front();
      if (tuser !== want.status)
        report($sformatf("result %0d status got %0d expected %0d", checked, tuser, want.status));
      if (pos !== want.position)
        report($sformatf("result %0d position got %0d expected %0d", checked, pos,
                         want.position));
      if (data !== want.data)
        report($sformatf("result %0d data got %08h expected %08h", checked, data, want.data));
      if (cnt !== want.count)
        report($sformatf("result %0d count got %0d expected %0d", checked, cnt, want.count));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CAP_W-1:0]      cfg_data = '0;

  table_scoreboard sb = new();
  bit              send_fast = 1'b0;
  logic [VAL_W-1:0] value_pool [POOL_SIZE];

  unique_integer_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] value,
                          input logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = send_fast ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {{(IN_DATA_W - VAL_W - IDX_W){1'b0}}, idx, value};
    do @(posedge clk); while (!in_tready);
    sb.note_cmd(cmd, value, idx);
    if ($urandom_range(0, 15) == 0) send_fast = ~send_fast;
  endtask

  // Stops offering items and waits for every owed result.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    sb.set_capacity(cap);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned       phase_cap [NUM_PHASES];
    int unsigned       clear_pct [NUM_PHASES];
    int unsigned       p;
    int unsigned       n;
    int unsigned       k;
    int unsigned       pick;
    logic [CMD_W-1:0]  cmd;
    logic [VAL_W-1:0]  value;
    logic [IDX_W-1:0]  idx;
    phase_cap = '{64, 64, 1, 0, 64, 5, 63, 64, 2, 64};
    clear_pct = '{0, 0, 2, 3, 2, 3, 1, 0, 4, 2};
    phase_cap[4] = $urandom_range(3, 62);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes of value and index, duplicates, misses and unknown commands.
    write_capacity(CAP_RESET);
    send_cmd(CMD_CLEAR, 32'h0000_0000, 6'd0);
    send_cmd(CMD_READ, 32'h0000_0000, 6'd0);
    send_cmd(CMD_FIND, 32'h0000_0000, 6'd0);
    send_cmd(CMD_APPEND, 32'h7FFF_FFFF, 6'd0);
    send_cmd(CMD_APPEND, 32'h8000_0000, 6'd0);
    send_cmd(CMD_UNIQUE, 32'h8000_0000, 6'd0);
    send_cmd(CMD_UNIQUE, 32'hFFFF_FFFF, 6'd0);
    send_cmd(CMD_APPEND, 32'h0000_0000, 6'd0);
    send_cmd(CMD_APPEND, 32'h8000_0000, 6'd0);
    send_cmd(CMD_FIND, 32'h8000_0000, 6'd0);
    send_cmd(CMD_FIND, 32'h0000_3039, 6'd0);
    send_cmd(CMD_READ, 32'h0000_0000, 6'd4);
    send_cmd(CMD_READ, 32'h0000_0000, IDX_LAST);
    send_cmd(CMD_FIRST_UNUSED, 32'hDEAD_BEEF, 6'd17);
    send_cmd(CMD_LAST_CODE, 32'hFFFF_FFFF, IDX_LAST);

    // Capacity below the fill count: appends are full, searches and reads still work.
    settle();
    write_capacity(7'd2);
    send_cmd(CMD_APPEND, 32'h0000_0001, 6'd0);
    send_cmd(CMD_UNIQUE, 32'h0000_0001, 6'd0);
    send_cmd(CMD_UNIQUE, 32'hFFFF_FFFF, 6'd0);
    send_cmd(CMD_READ, 32'h0000_0000, 6'd3);

    settle();
    write_capacity(7'd0);
    send_cmd(CMD_CLEAR, 32'h0000_0000, 6'd0);
    send_cmd(CMD_APPEND, 32'h0000_0005, 6'd0);
    send_cmd(CMD_UNIQUE, 32'h0000_0005, 6'd0);
    send_cmd(CMD_FIND, 32'h0000_0005, 6'd0);

    // The table carries over between phases, so a low capacity often meets a fuller table.
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_capacity(phase_cap[p][CAP_W-1:0]);
      for (k = 0; k < POOL_SIZE; k++) value_pool[k] = $urandom;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < clear_pct[p]) cmd = CMD_CLEAR;
        else if (pick < 35) cmd = CMD_APPEND;
        else if (pick < 60) cmd = CMD_UNIQUE;
        else if (pick < 78) cmd = CMD_FIND;
        else if (pick < 95) cmd = CMD_READ;
        else cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
        // A small pool of values makes duplicates and search hits common.
        if ($urandom_range(0, 3) == 0) value = $urandom;
        else value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (sb.fill != 0 && $urandom_range(0, 1) == 1)
          idx = IDX_W'($urandom_range(0, sb.fill - 1));
        else idx = IDX_W'($urandom_range(0, IDX_LAST));
        send_cmd(cmd, value, idx);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Draws a wait before each result; once it holds off long enough for the input to stall.
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    bit          fast;
    taken = 0;
    fast = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      else gap = fast ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata, out_tuser);
      taken++;
      if ($urandom_range(0, 15) == 0) fast = ~fast;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    do @(posedge clk); while (!rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
design/uit_pkg.sv
design/uit_ram.sv
design/unique_integer_table.sv
tb/tb.sv
